>>> hdl/mfbd_pkg.sv
// ----------------------------------------------------------------------------
// mfbd_pkg: shared definitions for the monochrome frame buffer bar drawer
// Screen geometry, store layout, command codes, sequencer states and the
// structs that pass between the sequencer, the mask generator and the store.
// ----------------------------------------------------------------------------
package mfbd_pkg;

  // Screen and store geometry.
  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_BYTES   = SCREEN_WIDTH * PAGE_COUNT;
  localparam int ADDR_W        = $clog2(STORE_BYTES);
  localparam int COL_IDX_W     = $clog2(SCREEN_WIDTH);
  localparam int PAGE_IDX_W    = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

  // Signed coordinate widths: columns reach x+w-1, rows reach y+h-1 and y-1.
  localparam int COL_W = 11;
  localparam int ROW_W = 10;

  // Fill arithmetic. The fill width is (pq8 * (w-2)) / 25600, taken as
  // ((product >> 8) / 100), and the division by 100 is a reciprocal multiply
  // that is exact for every dividend below 43690.
  localparam int FULL_PERCENT_Q8 = 25600;
  localparam int PQ_W            = 15;
  localparam int WM2_W           = 8;
  localparam int PROD_W          = PQ_W + WM2_W;
  localparam int QUOT_IN_W       = PROD_W - 8;
  localparam int RECIP_100       = 5243;
  localparam int RECIP_W         = 13;
  localparam int RECIP_SHIFT     = 19;
  localparam int FILL_W          = 8;

  // Command codes carried by the action field.
  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_PIXEL = 2'd1,
    ACT_BAR   = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_READ_WAIT,
    ST_MUL,
    ST_DIV,
    ST_RANGE,
    ST_WALK,
    ST_FINISH
  } state_t;

  // Kinds of store access.
  typedef enum logic [1:0] {
    OP_READ,
    OP_RMW,
    OP_ZERO
  } op_kind_t;

  // One store access issued by the sequencer.
  typedef struct packed {
    logic                valid;
    op_kind_t            kind;
    logic [ADDR_W-1:0]   addr;
    logic [7:0]          mask;
    logic                set;
  } store_op_t;

  // Drawing geometry held for the duration of a pixel or bar command.
  typedef struct packed {
    logic [COL_W-1:0] x;
    logic [COL_W-1:0] x_right;
    logic [COL_W-1:0] x_fill;
    logic [ROW_W-1:0] y;
    logic [ROW_W-1:0] y_bot;
    logic             has_rows;
  } geom_t;

endpackage

>>> hdl/mono_framebuffer_bar_draw_core.sv
// ----------------------------------------------------------------------------
// mono_framebuffer_bar_draw_core: monochrome page frame store with bar drawing
// Accepts clear, pixel, bar and read commands and returns one word per command.
// ----------------------------------------------------------------------------
// Sequence: read via ST_READ and ST_READ_WAIT; pixel and bar via ST_MUL, ST_DIV
//   and ST_RANGE, then, unless clipped, one store byte per cycle through the
//   read-modify-write port; clear, one zero write per cycle; then output wait.
// Throughput: one command at a time; the next is taken once the result is
//   in the output register.
// Reset: a clearing pass zeroes all STORE_BYTES bytes of the store; in_stall is
//   high throughout.
module mono_framebuffer_bar_draw_core
  import mfbd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        action,
  input  logic signed [8:0] x_pos,
  input  logic signed [7:0] y_pos,
  input  logic              pixel_value,
  input  logic [7:0]        bar_width,
  input  logic [6:0]        bar_height,
  input  logic [14:0]       fill_percent_q8,
  input  logic [9:0]        byte_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        byte_value
);

  state_t                  state;
  state_t                  state_next;
  logic [ADDR_W-1:0]       clr_cnt;
  logic                    clr_reply;
  logic signed [COL_W-1:0] x_reg;
  logic signed [COL_W-1:0] x_right;
  logic signed [COL_W-1:0] x_fill;
  logic signed [ROW_W-1:0] y_reg;
  logic signed [ROW_W-1:0] y_bot;
  logic                    has_rows;
  logic                    set_reg;
  logic [PQ_W-1:0]         pq_sat;
  logic [WM2_W-1:0]        wm2;
  logic [PROD_W-1:0]       prod;
  logic [FILL_W-1:0]       fill;
  logic [COL_IDX_W-1:0]    c_start;
  logic [COL_IDX_W-1:0]    c_end;
  logic [PAGE_IDX_W-1:0]   p_start;
  logic [PAGE_IDX_W-1:0]   p_end;
  logic                    range_empty;
  logic [COL_IDX_W-1:0]    col;
  logic [PAGE_IDX_W-1:0]   page;
  logic [9:0]              rd_idx;
  logic [7:0]              result_byte;

  logic                    accept;
  logic                    out_free;
  logic                    rd_ok;
  logic                    walk_last;
  logic                    clr_last;
  logic [7:0]              walk_mask;
  logic [7:0]              rdata;
  store_op_t               op;
  geom_t                   geom;

  logic signed [COL_W-1:0] x_ext;
  logic signed [ROW_W-1:0] y_ext;
  logic signed [COL_W-1:0] clo;
  logic signed [COL_W-1:0] chi;
  logic signed [COL_W-1:0] clo_c;
  logic signed [COL_W-1:0] chi_c;
  logic signed [ROW_W-1:0] rlo;
  logic signed [ROW_W-1:0] rhi;
  logic signed [ROW_W-1:0] rlo_c;
  logic signed [ROW_W-1:0] rhi_c;
  logic [QUOT_IN_W+RECIP_W-1:0] quot_full;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign rd_ok    = (rd_idx < STORE_BYTES);
  assign clr_last = (clr_cnt == ADDR_W'(STORE_BYTES - 1));
  assign walk_last = (col == c_end) && (page == p_end);

  assign x_ext = {{(COL_W - 9){x_pos[8]}}, x_pos};
  assign y_ext = {{(ROW_W - 8){y_pos[7]}}, y_pos};

  // Clipping of the drawn column and row spans to the screen.
  always_comb begin
    clo   = (x_reg <= x_right) ? x_reg : x_right;
    chi   = (x_reg <= x_right) ? x_right : x_reg;
    rlo   = (y_reg <= y_bot) ? y_reg : y_bot;
    rhi   = (y_reg <= y_bot) ? y_bot : y_reg;
    clo_c = (clo < 0) ? '0 : clo;
    chi_c = (chi > $signed(COL_W'(SCREEN_WIDTH - 1))) ? $signed(COL_W'(SCREEN_WIDTH - 1)) : chi;
    rlo_c = (rlo < 0) ? '0 : rlo;
    rhi_c = (rhi > $signed(ROW_W'(SCREEN_HEIGHT - 1))) ?
            $signed(ROW_W'(SCREEN_HEIGHT - 1)) : rhi;
  end

  // Division of the scaled product by 100 through its reciprocal.
  assign quot_full = prod[PROD_W-1:8] * RECIP_W'(RECIP_100);

  // Geometry seen by the mask generator.
  assign geom.x        = x_reg;
  assign geom.x_right  = x_right;
  assign geom.x_fill   = x_fill;
  assign geom.y        = y_reg;
  assign geom.y_bot    = y_bot;
  assign geom.has_rows = has_rows;

  mfbd_mask_gen u_mask_gen (
    .geom (geom),
    .col  (col),
    .page (page),
    .mask (walk_mask)
  );

  mfbd_store u_store (
    .clk   (clk),
    .rst   (rst),
    .op    (op),
    .rdata (rdata)
  );

  // Next-state logic of the command sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (action_t'(action))
            ACT_CLEAR: state_next = ST_CLEAR;
            ACT_PIXEL: state_next = ST_MUL;
            ACT_BAR:   state_next = ST_MUL;
            ACT_READ:  state_next = ST_READ;
          endcase
        end
      end
      ST_CLEAR: begin
        if (clr_last) begin
          state_next = clr_reply ? ST_FINISH : ST_IDLE;
        end
      end
      ST_READ:      state_next = ST_READ_WAIT;
      ST_READ_WAIT: state_next = ST_FINISH;
      ST_MUL:       state_next = ST_DIV;
      ST_DIV:       state_next = ST_RANGE;
      ST_RANGE:     state_next = range_empty ? ST_FINISH : ST_WALK;
      ST_WALK: begin
        if (walk_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: input stall and the store access.
  always_comb begin
    in_stall = (state != ST_IDLE);
    op.valid = 1'b0;
    op.kind  = OP_READ;
    op.addr  = ADDR_W'(rd_idx);
    op.mask  = walk_mask;
    op.set   = set_reg;
    unique case (state)
      ST_CLEAR: begin
        op.valid = 1'b1;
        op.kind  = OP_ZERO;
        op.addr  = clr_cnt;
      end
      ST_READ: begin
        op.valid = rd_ok;
        op.kind  = OP_READ;
      end
      ST_WALK: begin
        op.valid = 1'b1;
        op.kind  = OP_RMW;
        op.addr  = ADDR_W'(page * SCREEN_WIDTH) + ADDR_W'(col);
      end
      default: begin
      end
    endcase
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Clearing pass counter and whether the pass answers a command.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      clr_reply <= 1'b0;
    end else if (state == ST_CLEAR) begin
      clr_cnt <= clr_last ? '0 : clr_cnt + ADDR_W'(1);
    end else if (accept) begin
      clr_cnt   <= '0;
      clr_reply <= 1'b1;
    end
  end

  // Command capture and the setup steps of a drawing command.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_idx      <= byte_index;
      result_byte <= 8'h00;
      x_reg       <= x_ext;
      y_reg       <= y_ext;
      if (action_t'(action) == ACT_BAR) begin
        x_right  <= x_ext + COL_W'(bar_width) - COL_W'(1);
        y_bot    <= y_ext + ROW_W'(bar_height) - ROW_W'(1);
        has_rows <= (bar_width != 8'd0);
        set_reg  <= 1'b1;
        wm2      <= (bar_width > 8'd2) ? bar_width - 8'd2 : '0;
        pq_sat   <= (fill_percent_q8 > PQ_W'(FULL_PERCENT_Q8)) ?
                    PQ_W'(FULL_PERCENT_Q8) : fill_percent_q8;
      end else begin
        // A pixel is a one by one bar without fill.
        x_right  <= x_ext;
        y_bot    <= y_ext;
        has_rows <= 1'b1;
        set_reg  <= pixel_value;
        wm2      <= '0;
        pq_sat   <= '0;
      end
    end
    if (state == ST_MUL) begin
      prod        <= pq_sat * wm2;
      c_start     <= COL_IDX_W'(clo_c);
      c_end       <= COL_IDX_W'(chi_c);
      p_start     <= PAGE_IDX_W'(rlo_c[ROW_W-1:3]);
      p_end       <= PAGE_IDX_W'(rhi_c[ROW_W-1:3]);
      range_empty <= (chi < 0) || (clo > $signed(COL_W'(SCREEN_WIDTH - 1))) ||
                     (rhi < 0) || (rlo > $signed(ROW_W'(SCREEN_HEIGHT - 1)));
    end
    if (state == ST_DIV) begin
      fill <= FILL_W'(quot_full >> RECIP_SHIFT);
    end
    if (state == ST_RANGE) begin
      x_fill <= x_reg + COL_W'(fill);
      col    <= c_start;
      page   <= p_start;
    end
    if (state == ST_WALK) begin
      if (page == p_end) begin
        page <= p_start;
        col  <= col + COL_IDX_W'(1);
      end else begin
        page <= page + PAGE_IDX_W'(1);
      end
    end
    if (state == ST_READ_WAIT) begin
      result_byte <= rd_ok ? rdata : 8'h00;
    end
  end

  // Output register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_FINISH) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if ((state == ST_FINISH) && out_free) begin
      byte_value <= result_byte;
    end
  end

endmodule

>>> hdl/mfbd_mask_gen.sv
// ----------------------------------------------------------------------------
// mfbd_mask_gen: page mask for one column of a drawing command
// Works out which of the eight rows of one store byte belong to the outline
// rows, the edge columns or the fill area of the current bar or pixel.
// ----------------------------------------------------------------------------
module mfbd_mask_gen
  import mfbd_pkg::*;
(
  input  geom_t                 geom,
  input  logic [COL_IDX_W-1:0]  col,
  input  logic [PAGE_IDX_W-1:0] page,
  output logic [7:0]            mask
);

  logic signed [COL_W-1:0] x_s;
  logic signed [COL_W-1:0] x_right_s;
  logic signed [COL_W-1:0] x_fill_s;
  logic signed [COL_W-1:0] col_s;
  logic signed [ROW_W-1:0] y_s;
  logic signed [ROW_W-1:0] y_bot_s;
  logic signed [ROW_W-1:0] row_base;
  logic signed [ROW_W-1:0] row_lim;
  logic signed [ROW_W-1:0] rows [8];
  logic                    is_edge;
  logic                    in_fill_col;

  assign x_s       = $signed(geom.x);
  assign x_right_s = $signed(geom.x_right);
  assign x_fill_s  = $signed(geom.x_fill);
  assign y_s       = $signed(geom.y);
  assign y_bot_s   = $signed(geom.y_bot);
  assign col_s     = $signed(COL_W'(col));
  assign row_base  = $signed(ROW_W'({page, 3'b000}));
  assign row_lim   = $signed(ROW_W'(SCREEN_HEIGHT));

  // Column-level conditions shared by all eight rows.
  assign is_edge     = (col_s == x_s) || (col_s == x_right_s);
  assign in_fill_col = (col_s > x_s) && (col_s <= x_fill_s);

  // Each bit is one row of the page; rows past the screen bottom stay clear.
  always_comb begin
    for (int n = 0; n < 8; n++) begin
      rows[n] = row_base + $signed(ROW_W'(n));
      mask[n] = (rows[n] < row_lim) &&
                ((geom.has_rows && ((rows[n] == y_s) || (rows[n] == y_bot_s))) ||
                 (is_edge && (rows[n] >= y_s) && (rows[n] <= y_bot_s)) ||
                 (in_fill_col && (rows[n] > y_s) && (rows[n] < y_bot_s)));
    end
  end

endmodule

>>> hdl/mfbd_store.sv
// ----------------------------------------------------------------------------
// mfbd_store: page-organized frame store with read-modify-write pipeline
// One synchronous memory of STORE_BYTES bytes. A read-modify-write access
// reads in one cycle and writes the merged byte in the next; a zero access
// writes at once; a read access returns the registered byte in the next cycle.
// ----------------------------------------------------------------------------
module mfbd_store
  import mfbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  store_op_t   op,
  output logic [7:0]  rdata
);

  logic [7:0]        mem [STORE_BYTES];
  logic              wb_valid;
  logic [ADDR_W-1:0] wb_addr;
  logic [7:0]        wb_mask;
  logic              wb_set;
  logic [7:0]        wb_data;

  // Merge the byte just read with the pending mask.
  assign wb_data = wb_set ? (rdata | wb_mask) : (rdata & ~wb_mask);

  // Write-back stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      wb_valid <= 1'b0;
    end else begin
      wb_valid <= op.valid && (op.kind == OP_RMW);
    end
  end

  // Write-back stage payload.
  always_ff @(posedge clk) begin
    wb_addr <= op.addr;
    wb_mask <= op.mask;
    wb_set  <= op.set;
  end

  // Memory array: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (op.valid && (op.kind == OP_ZERO)) begin
      mem[op.addr] <= 8'h00;
    end else if (wb_valid) begin
      mem[wb_addr] <= wb_data;
    end
    rdata <= mem[op.addr];
  end

endmodule

>>> hdl/mfbd_checker.sv
// ----------------------------------------------------------------------------
// mfbd_checker: port-level checks for the frame buffer bar drawer
// Watches the handshakes of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module mfbd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] byte_value
);

  // A stalled result word stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(byte_value))
    else $error("result word changed while stalled");

  // Commands are taken one at a time: an accepted word stalls the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second command word taken back to back");

  // The clearing pass after reset holds off commands.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> in_stall)
    else $error("command port open during reset clearing pass");

endmodule

bind mono_framebuffer_bar_draw_core mfbd_checker u_mfbd_checker (.*);
